// ----- sv/adcdc_pkg.sv -----
// ----------------------------------------------------------------------------
// adcdc_pkg
// Shared types and constants for the ADC audio DC-removal framer.
// ----------------------------------------------------------------------------
package adcdc_pkg;

	// default sizing
	localparam int MAX_BLOCK_FRAMES_DEF = 4096;
	localparam int FRAME_COUNT_BITS_DEF = 40;

	// field widths
	localparam int SAMPLE_W   = 12;
	localparam int AUDIO_W    = 16;
	localparam int TIME_W     = 60;
	localparam int RATE_W     = 19;
	localparam int BLOCK_W    = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = RATE_W;

	// conditioning constants
	localparam int Q_BITS     = 16;
	localparam int DC_SHIFT   = 10;
	localparam int GAIN_SHIFT = 4;
	localparam int LVL_W      = SAMPLE_W + Q_BITS;
	localparam int SCALED_W   = SAMPLE_W + 1 + GAIN_SHIFT;
	localparam logic [SAMPLE_W-1:0] MIDSCALE = SAMPLE_W'(2048);
	localparam logic signed [SCALED_W-1:0] SCALED_MAX = SCALED_W'(32767);
	localparam logic signed [SCALED_W-1:0] SCALED_MIN = SCALED_W'(-32768);

	// timestamp constants
	localparam int US_W        = 20;
	localparam int US_PER_SEC  = 1000000;

	// register reset values
	localparam logic               REMOVE_DC_RST   = 1'b1;
	localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST = RATE_W'(16000);
	localparam logic [BLOCK_W-1:0] BLOCK_FRAMES_RST = BLOCK_W'(256);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REMOVE_DC    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_FRAMES = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_XFER
	} state_t;

	typedef struct packed {
		logic take;
		logic mul_step;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic last_now;
		logic out_free;
	} status_t;

endpackage

// ----- sv/adcdc_dp.sv -----
// ----------------------------------------------------------------------------
// adcdc_dp
// Datapath: config registers, DC tracker, saturation, block counting,
// shift-add timestamp multiply, restoring divide and output register.
// ----------------------------------------------------------------------------
module adcdc_dp
	import adcdc_pkg::*;
#(
	parameter int MAX_BLOCK_FRAMES = MAX_BLOCK_FRAMES_DEF,
	parameter int FRAME_COUNT_BITS = FRAME_COUNT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	output status_t                    status,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic [SAMPLE_W-1:0]        raw_sample,
	input  logic                       out_stall,
	output logic                       out_valid,
	output logic signed [AUDIO_W-1:0]  audio_sample,
	output logic                       block_last,
	output logic [TIME_W-1:0]          block_time_us
);

	localparam int FW = $clog2(MAX_BLOCK_FRAMES + 1);
	localparam int CW = (FW > BLOCK_W) ? FW : BLOCK_W;
	localparam int F  = FRAME_COUNT_BITS;
	localparam int PW = FRAME_COUNT_BITS + US_W;
	localparam logic [PW-1:0] US_PW = PW'(US_PER_SEC);
	localparam logic [CW-1:0] LIMIT_MAX = CW'(MAX_BLOCK_FRAMES);

	logic                remove_dc_q;
	logic [RATE_W-1:0]   rate_q;
	logic [BLOCK_W-1:0]  bf_q;

	logic [LVL_W-1:0]    level_q;
	logic                seeded_q;
	logic [FW-1:0]       fill_q;
	logic [F-1:0]        frames_q;

	logic signed [AUDIO_W-1:0] aud_q;
	logic                last_q;
	logic [F-1:0]        msh_q;
	logic [PW-1:0]       acc_q;
	logic [RATE_W-1:0]   rem_q;

	logic                      out_valid_q;
	logic signed [AUDIO_W-1:0] audio_q;
	logic                      block_last_q;
	logic [TIME_W-1:0]         time_q;

	// dc tracker
	logic [LVL_W-1:0]          target, base, level_nx;
	logic signed [LVL_W:0]     diff, step;
	logic [SAMPLE_W-1:0]       sub;
	logic signed [SAMPLE_W:0]  centered;
	logic signed [SCALED_W-1:0] scaled;
	logic signed [AUDIO_W-1:0] aud_nx;

	assign target   = {raw_sample, {Q_BITS{1'b0}}};
	assign base     = seeded_q ? level_q : target;
	assign diff     = $signed({1'b0, target}) - $signed({1'b0, base});
	assign step     = diff >>> DC_SHIFT;
	// mean stays inside its range, so a modulo add is exact
	assign level_nx = base + step[LVL_W-1:0];
	assign sub      = remove_dc_q ? level_nx[LVL_W-1:Q_BITS] : MIDSCALE;
	assign centered = $signed({1'b0, raw_sample}) - $signed({1'b0, sub});
	assign scaled   = $signed({centered, {GAIN_SHIFT{1'b0}}});

	always_comb begin
		if (scaled > SCALED_MAX) begin
			aud_nx = SCALED_MAX[AUDIO_W-1:0];
		end else if (scaled < SCALED_MIN) begin
			aud_nx = SCALED_MIN[AUDIO_W-1:0];
		end else begin
			aud_nx = scaled[AUDIO_W-1:0];
		end
	end

	// block size clamp
	logic [CW-1:0] bf_ext, limit_c;
	logic [FW-1:0] limit, fill_nx;

	assign bf_ext = CW'(bf_q);
	always_comb begin
		if (bf_ext == '0) begin
			limit_c = CW'(1);
		end else if (bf_ext > LIMIT_MAX) begin
			limit_c = LIMIT_MAX;
		end else begin
			limit_c = bf_ext;
		end
	end
	assign limit   = limit_c[FW-1:0];
	assign fill_nx = fill_q + FW'(1);

	assign status.last_now = (fill_nx >= limit);
	assign status.out_free = !out_valid_q || !out_stall;

	// divide step
	logic [RATE_W:0] trial, trial_sub;
	logic            ge;

	assign trial     = {rem_q, acc_q[PW-1]};
	assign ge        = (trial >= {1'b0, rate_q});
	assign trial_sub = trial - {1'b0, rate_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remove_dc_q <= REMOVE_DC_RST;
			rate_q      <= SAMPLE_RATE_RST;
			bf_q        <= BLOCK_FRAMES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REMOVE_DC:    remove_dc_q <= cfg_data[0];
				CFG_SAMPLE_RATE:  rate_q      <= cfg_data[RATE_W-1:0];
				CFG_BLOCK_FRAMES: bf_q        <= cfg_data[BLOCK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			seeded_q <= 1'b0;
			fill_q   <= '0;
			frames_q <= '0;
		end else if (cmd.take) begin
			if (remove_dc_q) begin
				level_q  <= level_nx;
				seeded_q <= 1'b1;
			end
			if (status.last_now) begin
				fill_q   <= '0;
				frames_q <= frames_q + F'(fill_nx);
			end else begin
				fill_q <= fill_nx;
			end
		end
	end

	// timestamp unit: msb-first shift-add multiply, then restoring divide
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			aud_q  <= aud_nx;
			last_q <= status.last_now;
			msh_q  <= frames_q;
			acc_q  <= '0;
			rem_q  <= '0;
		end else if (cmd.mul_step) begin
			acc_q <= {acc_q[PW-2:0], 1'b0} + (msh_q[F-1] ? US_PW : '0);
			msh_q <= {msh_q[F-2:0], 1'b0};
		end else if (cmd.div_step) begin
			acc_q <= {acc_q[PW-2:0], ge};
			rem_q <= ge ? trial_sub[RATE_W-1:0] : trial[RATE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			audio_q      <= aud_q;
			block_last_q <= last_q;
			time_q       <= (last_q && rate_q != '0) ? TIME_W'(acc_q) : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign audio_sample  = audio_q;
	assign block_last    = block_last_q;
	assign block_time_us = time_q;

endmodule

// ----- sv/adcdc_ctrl.sv -----
// ----------------------------------------------------------------------------
// adcdc_ctrl
// Controller: sequences accept, timestamp multiply/divide and output transfer.
// ----------------------------------------------------------------------------
module adcdc_ctrl
	import adcdc_pkg::*;
#(
	parameter int FRAME_COUNT_BITS = FRAME_COUNT_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);

	localparam int PW  = FRAME_COUNT_BITS + US_W;
	localparam int CNW = $clog2(PW);
	localparam logic [CNW-1:0] MUL_LAST = CNW'(FRAME_COUNT_BITS - 1);
	localparam logic [CNW-1:0] DIV_LAST = CNW'(PW - 1);

	state_t         state_q, state_nx;
	logic [CNW-1:0] cnt_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = status.last_now ? ST_MUL : ST_XFER;
				end
			end
			ST_MUL: begin
				if (cnt_q == MUL_LAST) begin
					state_nx = ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_nx = ST_XFER;
				end
			end
			ST_XFER: begin
				if (status.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
			end
			ST_MUL:  cmd.mul_step = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_XFER: cmd.load_out = status.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_nx != state_q) begin
				cnt_q <= '0;
			end else if (state_q == ST_MUL || state_q == ST_DIV) begin
				cnt_q <= cnt_q + CNW'(1);
			end
		end
	end

endmodule

// ----- sv/adc_audio_dc_removal_framer.sv -----
// ----------------------------------------------------------------------------
// adc_audio_dc_removal_framer
// ADC sample conditioner with running-mean DC removal and block framing.
//
//  channel  signals                                   direction
//  in       in_valid/in_stall, raw_sample             sink
//  out      out_valid/out_stall, audio_sample,
//           block_last, block_time_us                 source
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  sink, always ready
//
// an item that does not end a block is accepted, then transferred
// an item that ends a block adds, between those steps, a bit-serial multiply
// by one million, then a restoring divide by the sample rate, one quotient
// bit per cycle
// reset leaves the output register empty and config at its defaults
// a new item is taken while the previous result waits in the output register
// ----------------------------------------------------------------------------
module adc_audio_dc_removal_framer
	import adcdc_pkg::*;
#(
	parameter int MAX_BLOCK_FRAMES = MAX_BLOCK_FRAMES_DEF,
	parameter int FRAME_COUNT_BITS = FRAME_COUNT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [SAMPLE_W-1:0]        raw_sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [AUDIO_W-1:0]  audio_sample,
	output logic                       block_last,
	output logic [TIME_W-1:0]          block_time_us,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	adcdc_ctrl #(
		.FRAME_COUNT_BITS(FRAME_COUNT_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	adcdc_dp #(
		.MAX_BLOCK_FRAMES(MAX_BLOCK_FRAMES),
		.FRAME_COUNT_BITS(FRAME_COUNT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.raw_sample    (raw_sample),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.audio_sample  (audio_sample),
		.block_last    (block_last),
		.block_time_us (block_time_us)
	);

endmodule

// ----- sv/adcdc_chk.sv -----
// ----------------------------------------------------------------------------
// adcdc_chk
// Port-level checks for the ADC audio DC-removal framer.
// ----------------------------------------------------------------------------
module adcdc_chk
	import adcdc_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic signed [AUDIO_W-1:0] audio_sample,
	input logic                      block_last,
	input logic [TIME_W-1:0]         block_time_us
);

	// a held result stays offered
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// a held result keeps its payload
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(audio_sample) && $stable(block_last)
			&& $stable(block_time_us))
		else $error("output payload changed while stalled");

	// timestamp only on the last item of a block
	a_time_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !block_last |-> block_time_us == '0)
		else $error("block_time_us nonzero off block end");

	// one item in flight: input is held off right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item accepted back to back");

endmodule

bind adc_audio_dc_removal_framer adcdc_chk u_adcdc_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.audio_sample  (audio_sample),
	.block_last    (block_last),
	.block_time_us (block_time_us)
);

// ----- tb/sv/sample_stream_checker.sv -----
// ----------------------------------------------------------------------------
// sample_stream_checker
// Watches the config, sample and output channels of the DC-removal framer.
// Keeps its own copy of the running mean, block fill and frame count, predicts
// every conditioned sample and compares it, field by field, with the block's
// output in order. Reports the number of failures and the results still due.
// ----------------------------------------------------------------------------
module sample_stream_checker
	import adcdc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [SAMPLE_W-1:0]       raw_sample,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic signed [AUDIO_W-1:0] audio_sample,
	input  logic                      block_last,
	input  logic [TIME_W-1:0]         block_time_us,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	output int                        pending_results,
	output int                        error_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic signed [AUDIO_W-1:0] audio;
		logic                      last;
		logic [TIME_W-1:0]         time_us;
	} framed_sample_t;

	// register copies
	logic                 remove_dc_q;
	logic [RATE_W-1:0]    sample_rate_q;
	logic [BLOCK_W-1:0]   block_frames_q;

	// conditioner and framer state
	logic [31:0]                      dc_level;
	logic                             dc_seeded;
	logic [BLOCK_W-1:0]               fill_count;
	logic [FRAME_COUNT_BITS_DEF-1:0]  frames_emitted;

	framed_sample_t expected_samples[$];
	framed_sample_t want;
	int             mismatches;

	function automatic framed_sample_t condition_sample(input logic [SAMPLE_W-1:0] s);
		logic signed [33:0]   target;
		logic signed [33:0]   diff;
		logic signed [13:0]   offset;
		logic signed [18:0]   scaled;
		logic [BLOCK_W-1:0]   limit;
		logic [63:0]          stamp;
		framed_sample_t       r;
		r = '0;
		if (remove_dc_q) begin
			target = {6'b0, s, 16'b0};
			if (!dc_seeded) begin
				dc_level = target[31:0];
				dc_seeded = 1'b1;
			end
			// mean moves by a floored 1/1024 of the error
			diff = target - $signed({2'b0, dc_level});
			dc_level = dc_level + 32'(diff >>> DC_SHIFT);
			offset = $signed({2'b0, s}) - $signed({2'b0, dc_level[27:16]});
		end else begin
			offset = $signed({2'b0, s}) - $signed({2'b0, MIDSCALE});
		end
		scaled = offset;
		scaled = scaled <<< GAIN_SHIFT;
		if (scaled > 32767)
			scaled = 32767;
		if (scaled < -32768)
			scaled = -32768;
		r.audio = scaled[AUDIO_W-1:0];

		if (block_frames_q == 0)
			limit = 1;
		else if (block_frames_q > MAX_BLOCK_FRAMES_DEF)
			limit = BLOCK_W'(MAX_BLOCK_FRAMES_DEF);
		else
			limit = block_frames_q;

		fill_count = fill_count + 1'b1;
		if (fill_count >= limit) begin
			r.last = 1'b1;
			if (sample_rate_q != 0) begin
				stamp = 64'(frames_emitted) * 64'(US_PER_SEC);
				stamp = stamp / 64'(sample_rate_q);
				r.time_us = stamp[TIME_W-1:0];
			end
			// advance by what the block actually held
			frames_emitted = frames_emitted + FRAME_COUNT_BITS_DEF'(fill_count);
			fill_count = '0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remove_dc_q = REMOVE_DC_RST;
			sample_rate_q = SAMPLE_RATE_RST;
			block_frames_q = BLOCK_FRAMES_RST;
			dc_level = '0;
			dc_seeded = 1'b0;
			fill_count = '0;
			frames_emitted = '0;
			expected_samples.delete();
			mismatches = 0;
			pending_results <= 0;
			error_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_REMOVE_DC:    remove_dc_q = cfg_data[0];
					CFG_SAMPLE_RATE:  sample_rate_q = cfg_data[RATE_W-1:0];
					CFG_BLOCK_FRAMES: block_frames_q = cfg_data[BLOCK_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_samples.push_back(condition_sample(raw_sample));
			if (out_valid && !out_stall) begin
				if (expected_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected output item: audio %0d last %0b time %0d",
							audio_sample, block_last, block_time_us);
				end else begin
					want = expected_samples.pop_front();
					if (audio_sample !== want.audio || block_last !== want.last ||
						block_time_us !== want.time_us) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$write("output mismatch: expected audio %0d last %0b time %0d,",
								want.audio, want.last, want.time_us);
							$display(" got audio %0d last %0b time %0d",
								audio_sample, block_last, block_time_us);
						end
					end
				end
			end
			pending_results <= expected_samples.size();
			error_count <= mismatches;
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the ADC audio DC-removal framer. Starts with short directed
// runs over sample extremes, both conditioning modes, odd block sizes and
// timestamp corner rates, then runs random config phases with random samples
// and random idling on both channels. Checking is done by the stream checker.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import adcdc_pkg::*;

	localparam int IDLE_LIMIT    = 5000;
	localparam int SETTLE_CYCLES = 200;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_SAMPLES = 93;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [SAMPLE_W-1:0]       raw_sample = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [AUDIO_W-1:0] audio_sample;
	logic                      block_last;
	logic [TIME_W-1:0]         block_time_us;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;

	int                        pending_results;
	int                        error_count;
	int                        idle_cycles = 0;
	logic                      quiet = 1'b0;
	logic [SAMPLE_W-1:0]       prev_sample = '0;

	adc_audio_dc_removal_framer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.raw_sample    (raw_sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.audio_sample  (audio_sample),
		.block_last    (block_last),
		.block_time_us (block_time_us),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	sample_stream_checker result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.raw_sample      (raw_sample),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.audio_sample    (audio_sample),
		.block_last      (block_last),
		.block_time_us   (block_time_us),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.pending_results (pending_results),
		.error_count     (error_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk)
		out_stall <= !quiet && ($urandom_range(99) < 8);

	// ends the run when nothing moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		if (!quiet && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_sample <= s;
		prev_sample = s;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// registers change only once every queued result has come out
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] prev);
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			// small steps around the last value let the mean settle
			2, 3, 4: return prev + SAMPLE_W'($urandom_range(32)) - SAMPLE_W'(16);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic random_setup();
		logic [RATE_W-1:0]  rate;
		logic [BLOCK_W-1:0] frames;
		case ($urandom_range(5))
			0: rate = '0;
			1: rate = RATE_W'(1);
			2: rate = '1;
			3: rate = RATE_W'(384000);
			default: rate = RATE_W'($urandom_range(384000, 1));
		endcase
		case ($urandom_range(9))
			0: frames = '0;
			1: frames = BLOCK_W'(MAX_BLOCK_FRAMES_DEF);
			2: frames = BLOCK_W'($urandom_range(8191, MAX_BLOCK_FRAMES_DEF + 1));
			3: frames = BLOCK_W'($urandom_range(300, 100));
			default: frames = BLOCK_W'($urandom_range(16, 1));
		endcase
		write_register(CFG_REMOVE_DC, CFG_DATA_W'($urandom));
		write_register(CFG_SAMPLE_RATE, rate);
		// upper data bits are don't-care for the block size
		write_register(CFG_BLOCK_FRAMES, {6'($urandom), frames});
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fixed midscale, zero rate, three-item blocks, mean left unseeded
		write_register(CFG_REMOVE_DC, CFG_DATA_W'(0));
		write_register(CFG_SAMPLE_RATE, CFG_DATA_W'(0));
		write_register(CFG_BLOCK_FRAMES, CFG_DATA_W'(3));
		send_sample(12'd0);
		send_sample(12'd4095);
		send_sample(12'd2048);
		send_sample(12'd2047);
		send_sample(12'd2049);
		send_sample(12'd1);

		// first dc-removal item seeds the mean, block size zero
		write_register(CFG_REMOVE_DC, CFG_DATA_W'(1));
		write_register(CFG_SAMPLE_RATE, CFG_DATA_W'(384000));
		write_register(CFG_BLOCK_FRAMES, CFG_DATA_W'(0));
		send_sample(12'd4095);
		send_sample(12'd0);
		send_sample(12'd4095);
		send_sample(12'd2048);

		// rate of one gives the widest timestamps
		write_register(CFG_BLOCK_FRAMES, CFG_DATA_W'(5));
		write_register(CFG_SAMPLE_RATE, CFG_DATA_W'(1));
		send_sample(12'd100);
		send_sample(12'd200);
		send_sample(12'd300);

		// block size drops below the current fill
		write_register(CFG_BLOCK_FRAMES, CFG_DATA_W'(2));
		send_sample(12'd4000);
		send_sample(12'd50);

		write_register(CFG_SPARE, '1);
		write_register(CFG_SAMPLE_RATE, '1);
		write_register(CFG_REMOVE_DC, CFG_DATA_W'(0));
		send_sample(12'd2048);
		send_sample(12'd3000);
		write_register(CFG_REMOVE_DC, '1);
		send_sample(12'd1000);
		send_sample(12'd1000);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			random_setup();
			quiet = (phase == 4 || phase == 5);
			for (int n = 0; n < PHASE_SAMPLES; n++)
				send_sample(pick_sample(prev_sample));
		end
		quiet = 1'b0;

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_results == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/adcdc_pkg.sv
sv/adcdc_dp.sv
sv/adcdc_ctrl.sv
sv/adc_audio_dc_removal_framer.sv
sv/adcdc_chk.sv
tb/sv/sample_stream_checker.sv
tb/sv/testbench.sv
